[src/integer_to_roman_encoder_macros.svh]
// Assertion shorthands for the checker file.
`ifndef INTEGER_TO_ROMAN_ENCODER_MACROS_SVH
`define INTEGER_TO_ROMAN_ENCODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define I2R_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define I2R_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/i2r_pkg.sv]
package i2r_pkg;

	localparam int unsigned VALUE_W  = 12;
	localparam int unsigned SYMBOL_W = 8;
	localparam int unsigned DIGIT_W  = 4;
	localparam int unsigned CHAR_W   = 3;
	localparam int unsigned POS_W    = 2;

	localparam logic [VALUE_W-1:0] VALUE_LIMIT = 12'd4000;

	localparam logic [SYMBOL_W-1:0] SYM_NONE = 8'h00;
	localparam logic [SYMBOL_W-1:0] SYM_I    = 8'h49;
	localparam logic [SYMBOL_W-1:0] SYM_V    = 8'h56;
	localparam logic [SYMBOL_W-1:0] SYM_X    = 8'h58;
	localparam logic [SYMBOL_W-1:0] SYM_L    = 8'h4C;
	localparam logic [SYMBOL_W-1:0] SYM_C    = 8'h43;
	localparam logic [SYMBOL_W-1:0] SYM_D    = 8'h44;
	localparam logic [SYMBOL_W-1:0] SYM_M    = 8'h4D;

	localparam logic [POS_W-1:0] POS_ONES      = 2'd0;
	localparam logic [POS_W-1:0] POS_TENS      = 2'd1;
	localparam logic [POS_W-1:0] POS_HUNDREDS  = 2'd2;
	localparam logic [POS_W-1:0] POS_THOUSANDS = 2'd3;

	typedef enum logic [2:0] {
		STEP_FETCH,
		STEP_CHECK,
		STEP_DIGIT,
		STEP_EMIT,
		STEP_NEXT,
		STEP_FAULT
	} step_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_LOAD,
		ACT_DIV,
		ACT_EMIT,
		ACT_NEXT,
		ACT_FAULT
	} act_t;

	typedef enum logic [2:0] {
		COND_IN_VALID,
		COND_BAD,
		COND_GE,
		COND_DONE,
		COND_REM_ZERO,
		COND_OUT_FREE
	} cond_t;

	typedef enum logic [1:0] {
		KIND_ONE,
		KIND_FIVE,
		KIND_TEN
	} kind_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		step_t jmp_t;
		step_t jmp_f;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic bad;
		logic ge;
		logic done;
		logic rem_zero;
		logic out_free;
	} status_t;

	// microprogram
	function automatic ctrl_t ucode(step_t s);
		ctrl_t w;
		case (s)
			STEP_FETCH: w = '{ACT_LOAD,  COND_IN_VALID, STEP_CHECK, STEP_FETCH};
			STEP_CHECK: w = '{ACT_NONE,  COND_BAD,      STEP_FAULT, STEP_DIGIT};
			STEP_DIGIT: w = '{ACT_DIV,   COND_GE,       STEP_DIGIT, STEP_EMIT};
			STEP_EMIT:  w = '{ACT_EMIT,  COND_DONE,     STEP_NEXT,  STEP_EMIT};
			STEP_NEXT:  w = '{ACT_NEXT,  COND_REM_ZERO, STEP_FETCH, STEP_DIGIT};
			STEP_FAULT: w = '{ACT_FAULT, COND_OUT_FREE, STEP_FETCH, STEP_FAULT};
			default:    w = '{ACT_NONE,  COND_IN_VALID, STEP_FETCH, STEP_FETCH};
		endcase
		return w;
	endfunction

	function automatic logic [VALUE_W-1:0] weight(logic [POS_W-1:0] pos);
		logic [VALUE_W-1:0] w;
		case (pos)
			POS_THOUSANDS: w = 12'd1000;
			POS_HUNDREDS:  w = 12'd100;
			POS_TENS:      w = 12'd10;
			default:       w = 12'd1;
		endcase
		return w;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_len(logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] n;
		case (d)
			4'd1, 4'd5:       n = 3'd1;
			4'd2, 4'd4, 4'd6,
			4'd9:             n = 3'd2;
			4'd3, 4'd7:       n = 3'd3;
			4'd8:             n = 3'd4;
			default:          n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic kind_t digit_kind(logic [DIGIT_W-1:0] d, logic [CHAR_W-1:0] k);
		kind_t t;
		case (d)
			4'd4:                   t = (k == 3'd0) ? KIND_ONE  : KIND_FIVE;
			4'd5, 4'd6, 4'd7, 4'd8: t = (k == 3'd0) ? KIND_FIVE : KIND_ONE;
			4'd9:                   t = (k == 3'd0) ? KIND_ONE  : KIND_TEN;
			default:                t = KIND_ONE;
		endcase
		return t;
	endfunction

	function automatic logic [SYMBOL_W-1:0] symbol_of(logic [POS_W-1:0] pos, kind_t t);
		logic [SYMBOL_W-1:0] s;
		case (pos)
			POS_ONES:      s = (t == KIND_ONE) ? SYM_I : (t == KIND_FIVE) ? SYM_V : SYM_X;
			POS_TENS:      s = (t == KIND_ONE) ? SYM_X : (t == KIND_FIVE) ? SYM_L : SYM_C;
			POS_HUNDREDS:  s = (t == KIND_ONE) ? SYM_C : (t == KIND_FIVE) ? SYM_D : SYM_M;
			default:       s = SYM_M;
		endcase
		return s;
	endfunction

endpackage

[src/i2r_useq.sv]
module i2r_useq (
	input  logic             clk,
	input  logic             arst_n,
	input  i2r_pkg::status_t status,
	output i2r_pkg::ctrl_t   ctrl
);
	import i2r_pkg::*;

	step_t step_q;
	step_t step_d;
	logic  taken;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_FETCH;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		ctrl = ucode(step_q);
		case (ctrl.cond)
			COND_IN_VALID: taken = status.in_valid;
			COND_BAD:      taken = status.bad;
			COND_GE:       taken = status.ge;
			COND_DONE:     taken = status.done;
			COND_REM_ZERO: taken = status.rem_zero;
			COND_OUT_FREE: taken = status.out_free;
			default:       taken = 1'b0;
		endcase
		step_d = taken ? ctrl.jmp_t : ctrl.jmp_f;
	end

endmodule

[src/i2r_datapath.sv]
module i2r_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  i2r_pkg::ctrl_t                ctrl,
	output i2r_pkg::status_t              status,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [i2r_pkg::VALUE_W-1:0]   in_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [i2r_pkg::SYMBOL_W-1:0]  out_symbol,
	output logic                          out_last,
	output logic                          out_error
);
	import i2r_pkg::*;

	logic [VALUE_W-1:0]  rem_q;
	logic [POS_W-1:0]    pos_q;
	logic [DIGIT_W-1:0]  digit_q;
	logic [CHAR_W-1:0]   char_q;
	logic                bad_q;
	logic                valid_q;
	logic [SYMBOL_W-1:0] symbol_q;
	logic                last_q;
	logic                error_q;

	logic [VALUE_W-1:0]  w;
	logic [CHAR_W-1:0]   len;
	logic                out_free;
	logic                load_char;
	logic                load_fault;

	assign w          = weight(pos_q);
	assign len        = digit_len(digit_q);
	assign out_free   = !valid_q || out_ready;
	assign load_char  = (ctrl.act == ACT_EMIT) && out_free && (char_q != len);
	assign load_fault = (ctrl.act == ACT_FAULT) && out_free;

	assign in_ready = (ctrl.act == ACT_LOAD);

	assign status.in_valid = in_valid;
	assign status.bad      = bad_q;
	assign status.ge       = (rem_q >= w);
	assign status.done     = (char_q == len);
	assign status.rem_zero = (rem_q == '0);
	assign status.out_free = out_free;

	always_ff @(posedge clk) begin
		case (ctrl.act)
			ACT_LOAD: begin
				rem_q   <= in_value;
				bad_q   <= (in_value == '0) || (in_value >= VALUE_LIMIT);
				pos_q   <= POS_THOUSANDS;
				digit_q <= '0;
				char_q  <= '0;
			end
			ACT_DIV: begin
				if (rem_q >= w) begin
					rem_q   <= rem_q - w;
					digit_q <= digit_q + 4'd1;
				end
			end
			ACT_EMIT: begin
				if (load_char) begin
					char_q <= char_q + 3'd1;
				end
			end
			ACT_NEXT: begin
				pos_q   <= pos_q - 2'd1;
				digit_q <= '0;
				char_q  <= '0;
			end
			default: begin
			end
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_char || load_fault) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_char) begin
			symbol_q <= symbol_of(pos_q, digit_kind(digit_q, char_q));
			// nothing left below this digit means this is the final word
			last_q   <= (char_q == len - 3'd1) && (rem_q == '0);
			error_q  <= 1'b0;
		end else if (load_fault) begin
			symbol_q <= SYM_NONE;
			last_q   <= 1'b1;
			error_q  <= 1'b1;
		end
	end

	assign out_valid  = valid_q;
	assign out_symbol = symbol_q;
	assign out_last   = last_q;
	assign out_error  = error_q;

endmodule

[src/integer_to_roman_encoder.sv]
// Converts a 12-bit unsigned value on the input stream into its Roman numeral, one uppercase
// ASCII character per output word, most significant first, with tlast on the final character.
// Zero or any value of 4000 and above yields a single word with tdata zero, tlast and tuser
// set. Items are handled one at a time. A small microprogram drives one subtract-and-compare
// unit that peels off each decimal digit by repeated subtraction of its weight, one per
// cycle, then emits that digit's characters one per cycle whenever the output can take them.
// An item goes through load and check, then for each position from the thousands down to the
// last nonzero digit through the extraction steps, an emit step for each character plus a
// step to see the digit finished, and an advance step; without backpressure 3888 is the
// slowest case. An out-of-range value goes through load, check and fault. The output word
// register lets the next item load while the last word waits.
module integer_to_roman_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [11:0] value, [15:12] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [7:0] symbol
	output logic        m_tlast,
	output logic        m_tuser   // [0] range_error
);
	import i2r_pkg::*;

	ctrl_t   ctrl;
	status_t status;

	i2r_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	i2r_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.status     (status),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_value   (s_tdata[VALUE_W-1:0]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_symbol (m_tdata),
		.out_last   (m_tlast),
		.out_error  (m_tuser)
	);

endmodule

[src/i2r_checker.sv]
`include "integer_to_roman_encoder_macros.svh"

module i2r_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       m_tuser
);
	import i2r_pkg::*;

	logic       sym_legal;
	logic       m_stall;
	logic [9:0] m_word;

	assign sym_legal = m_tdata inside {SYM_I, SYM_V, SYM_X, SYM_L, SYM_C, SYM_D, SYM_M};
	assign m_stall   = m_tvalid && !m_tready;
	assign m_word    = {m_tuser, m_tlast, m_tdata};

	// an error word stands alone
	`I2R_ASSERT_NOW(a_err_word, m_tvalid && m_tuser, m_tlast && m_tdata == SYM_NONE, "bad error word")

	`I2R_ASSERT_NOW(a_sym_legal, m_tvalid && !m_tuser, sym_legal, "illegal symbol")

	// one item at a time: no back-to-back accepts
	`I2R_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "input taken twice in a row")

	`I2R_ASSERT_NEXT(a_out_hold, m_stall, m_tvalid && $stable(m_word), "word changed in stall")

endmodule

bind integer_to_roman_encoder i2r_checker u_i2r_checker (.*);

[tb/tb_integer_to_roman_encoder.sv]
module tb_integer_to_roman_encoder;
	import i2r_pkg::*;

	typedef struct packed {
		logic [SYMBOL_W-1:0] symbol;
		logic                last;
		logic                range_error;
	} roman_word_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               typed;  // expected word given below instead of predicted
		roman_word_t        word;
	} dir_row_t;

	localparam roman_word_t RANGE_ERR_WORD = '{SYM_NONE, 1'b1, 1'b1};
	localparam roman_word_t UNIT_WORD      = '{SYM_I, 1'b1, 1'b0};
	localparam roman_word_t NO_WORD        = '{SYM_NONE, 1'b0, 1'b0};
	localparam int unsigned STALL_LIMIT    = 2000;
	localparam int unsigned LONG_HOLD      = 300;
	localparam int unsigned TAIL_CYCLES    = 60;

	localparam dir_row_t DIR_ROWS [24] = '{
		'{12'd0,    1'b1, RANGE_ERR_WORD},
		'{12'd1,    1'b1, UNIT_WORD},
		'{12'd4000, 1'b1, RANGE_ERR_WORD},
		'{12'd4095, 1'b1, RANGE_ERR_WORD},
		'{12'd4001, 1'b1, RANGE_ERR_WORD},
		'{12'd3999, 1'b0, NO_WORD},
		'{12'd3888, 1'b0, NO_WORD},
		'{12'd3,    1'b0, NO_WORD},
		'{12'd4,    1'b0, NO_WORD},
		'{12'd5,    1'b0, NO_WORD},
		'{12'd7,    1'b0, NO_WORD},
		'{12'd8,    1'b0, NO_WORD},
		'{12'd9,    1'b0, NO_WORD},
		'{12'd14,   1'b0, NO_WORD},
		'{12'd40,   1'b0, NO_WORD},
		'{12'd90,   1'b0, NO_WORD},
		'{12'd400,  1'b0, NO_WORD},
		'{12'd500,  1'b0, NO_WORD},
		'{12'd900,  1'b0, NO_WORD},
		'{12'd1000, 1'b0, NO_WORD},
		'{12'd3000, 1'b0, NO_WORD},
		'{12'd2048, 1'b0, NO_WORD},
		'{12'd1994, 1'b0, NO_WORD},
		'{12'd444,  1'b0, NO_WORD}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;  // [11:0] value, [15:12] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;       // [7:0] symbol
	logic        m_tlast;
	logic        m_tuser;       // [0] range_error

	roman_word_t chars_due[$];
	int unsigned values_sent;
	int unsigned bad_values_sent;
	int unsigned chars_seen;
	int unsigned longest_numeral;
	int unsigned mismatches;
	int unsigned quiet_cycles;
	int unsigned hold_left;
	bit          tx_idle = 1'b1;
	bit          rx_idle = 1'b1;
	bit          long_hold_req = 1'b0;

	integer_to_roman_encoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #2 clk = ~clk;

	// mostly back to back, sometimes a few cycles, rarely a long gap
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return 0;
		if (r < 9)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [VALUE_W-1:0] rand_value();
		int unsigned r;
		int unsigned v;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return VALUE_W'($urandom_range(4000, 4095));
		if (r < 7) begin
			// long numerals: lead with 1 to 3, then lean on the digit 8
			v = $urandom_range(1, 3);
			repeat (3)
				v = v * 10 + (($urandom_range(0, 1) != 0) ? 8 : $urandom_range(0, 9));
			return VALUE_W'(v);
		end
		return VALUE_W'($urandom_range(1, 3999));
	endfunction

	// queue up the characters one value should turn into
	function automatic void predict_numeral(logic [VALUE_W-1:0] v);
		logic [SYMBOL_W-1:0] chars[$];
		logic [SYMBOL_W-1:0] one, five, ten;
		int unsigned         place;
		int unsigned         dig;
		if (v == '0 || v >= VALUE_LIMIT) begin
			chars_due.push_back(RANGE_ERR_WORD);
			bad_values_sent++;
			return;
		end
		for (int p = 3; p >= 0; p--) begin
			case (p)
				3: begin place = 1000; one = SYM_M; five = SYM_NONE; ten = SYM_NONE; end
				2: begin place = 100;  one = SYM_C; five = SYM_D;    ten = SYM_M;    end
				1: begin place = 10;   one = SYM_X; five = SYM_L;    ten = SYM_C;    end
				default: begin place = 1; one = SYM_I; five = SYM_V; ten = SYM_X;    end
			endcase
			dig = (int'(v) / place) % 10;
			if (dig >= 1 && dig <= 3) begin
				repeat (dig) chars.push_back(one);
			end else if (dig == 4) begin
				chars.push_back(one);
				chars.push_back(five);
			end else if (dig >= 5 && dig <= 8) begin
				chars.push_back(five);
				repeat (dig - 5) chars.push_back(one);
			end else if (dig == 9) begin
				chars.push_back(one);
				chars.push_back(ten);
			end
		end
		foreach (chars[k])
			chars_due.push_back('{chars[k], k == chars.size() - 1, 1'b0});
		if (chars.size() > longest_numeral)
			longest_numeral = chars.size();
	endfunction

	task automatic report_mismatch(string what, int unsigned want, int unsigned got);
		$display("MISMATCH char %0d: %s expected 0x%0h got 0x%0h", chars_seen, what, want, got);
		mismatches++;
	endtask

	task automatic push_value(logic [VALUE_W-1:0] v, logic typed, roman_word_t word);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {4'h0, v};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (typed) begin
			chars_due.push_back(word);
			if (word.range_error)
				bad_values_sent++;
		end else begin
			predict_numeral(v);
		end
		values_sent++;
		gap = tx_idle ? pick_gap() : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// every accepted value leaves at least one char due, so time always advances here
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (chars_due.size() != 0)
			@(posedge clk);
	endtask

	// receiver
	initial begin
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left != 0)
				hold_left--;
			else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end else if (rx_idle)
				hold_left = pick_gap();
			m_tready <= (hold_left == 0);
		end
	end

	// output checker
	always @(posedge clk) begin
		roman_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (chars_due.size() == 0) begin
				report_mismatch("unexpected word, symbol", 0, 32'(m_tdata));
			end else begin
				want = chars_due.pop_front();
				if (m_tdata !== want.symbol)
					report_mismatch("symbol", 32'(want.symbol), 32'(m_tdata));
				if (m_tlast !== want.last)
					report_mismatch("last", 32'(want.last), 32'(m_tlast));
				if (m_tuser !== want.range_error)
					report_mismatch("range_error", 32'(want.range_error), 32'(m_tuser));
			end
			chars_seen++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d chars still due",
					STALL_LIMIT, chars_due.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_ROWS[i])
			push_value(DIR_ROWS[i].value, DIR_ROWS[i].typed, DIR_ROWS[i].word);
		wait_drained();

		repeat (100) push_value(rand_value(), 1'b0, NO_WORD);

		// receiver stalls for a long stretch while words keep coming
		tx_idle = 1'b0;
		long_hold_req = 1'b1;
		repeat (40) push_value(rand_value(), 1'b0, NO_WORD);

		// full rate on both sides
		rx_idle = 1'b0;
		repeat (60) push_value(rand_value(), 1'b0, NO_WORD);
		wait_drained();

		tx_idle = 1'b1;
		rx_idle = 1'b1;
		repeat (100) push_value(rand_value(), 1'b0, NO_WORD);
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Converted %0d values (%0d out of range) into %0d checked chars",
			values_sent, bad_values_sent, chars_seen);
		$display("Longest numeral %0d chars, idle gaps and a %0d-cycle output stall, %0d mismatches",
			longest_numeral, LONG_HOLD, mismatches);
		if (mismatches == 0 && chars_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[filelist.f]
+incdir+src
src/i2r_pkg.sv
src/i2r_useq.sv
src/i2r_datapath.sv
src/integer_to_roman_encoder.sv
src/i2r_checker.sv
tb/tb_integer_to_roman_encoder.sv
